// ===== src/rsk_pkg.sv =====
// ---------------------------------------------------------------------------
// rsk_pkg
// Shared sizes and the command and status types that pass between the
// sorter's controller and its datapath.
// ---------------------------------------------------------------------------
package rsk_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int KEY_BITS    = 16;
  localparam int KEY_FIELD_W = 16;
  localparam int TAG_W       = 8;

  // held key width: key bits above KEY_BITS are dropped at the input
  localparam int KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic insert;  // place the input record into the sorted chain
    logic drop;    // input record finds the chain full
    logic pop;     // head record leaves, chain moves one place down
  } rsk_cmd_t;

  typedef struct packed {
    logic full;    // every cell holds a record
    logic last;    // exactly one record held
  } rsk_stat_t;

endpackage

// ===== src/rsk_in_if.sv =====
// ---------------------------------------------------------------------------
// rsk_in_if
// Record input channel: valid/ready handshake with key, tag and set end mark.
// ---------------------------------------------------------------------------
interface rsk_in_if;
  logic                            valid;
  logic                            ready;
  logic [rsk_pkg::KEY_FIELD_W-1:0] sort_key;
  logic [rsk_pkg::TAG_W-1:0]       record_tag;
  logic                            final_record;

  modport source (output valid, output sort_key, output record_tag,
                  output final_record, input ready);
  modport sink   (input valid, input sort_key, input record_tag,
                  input final_record, output ready);
endinterface

// ===== src/rsk_out_if.sv =====
// ---------------------------------------------------------------------------
// rsk_out_if
// Sorted result channel: valid/ready handshake with key, tag and flags.
// ---------------------------------------------------------------------------
interface rsk_out_if;
  logic                            valid;
  logic                            ready;
  logic [rsk_pkg::KEY_FIELD_W-1:0] out_key;
  logic [rsk_pkg::TAG_W-1:0]       out_tag;
  logic                            last_out;
  logic                            overflow;

  modport source (output valid, output out_key, output out_tag,
                  output last_out, output overflow, input ready);
  modport sink   (input valid, input out_key, input out_tag,
                  input last_out, input overflow, output ready);
endinterface

// ===== src/rsk_datapath.sv =====
// ---------------------------------------------------------------------------
// rsk_datapath
// Sorted insertion chain: every cell compares the incoming key with its own
// in parallel, so a record drops into place in one cycle. Emission shifts
// the chain toward cell 0, whose record is the result shown.
// ---------------------------------------------------------------------------
module rsk_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsk_pkg::rsk_cmd_t               cmd,
  output rsk_pkg::rsk_stat_t              stat,
  input  logic [rsk_pkg::KEY_FIELD_W-1:0] in_key,
  input  logic [rsk_pkg::TAG_W-1:0]       in_tag,
  output logic [rsk_pkg::KEY_FIELD_W-1:0] head_key,
  output logic [rsk_pkg::TAG_W-1:0]       head_tag,
  output logic                            dropped
);
  import rsk_pkg::*;

  key_t key_r   [MAX_RECORDS];
  key_t key_nxt [MAX_RECORDS];
  tag_t tag_r   [MAX_RECORDS];
  tag_t tag_nxt [MAX_RECORDS];

  logic [MAX_RECORDS-1:0] ge;
  cnt_t fill_r, fill_nxt;
  logic dropped_r, dropped_nxt;
  key_t new_key;

  assign new_key = in_key[KEY_W-1:0];

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    key_t key_below, key_above;
    tag_t tag_below, tag_above;
    logic ge_below;
    logic take_new;

    // held record not smaller than the new one: new record goes in front
    assign ge[i] = (cnt_t'(i) < fill_r) && (key_r[i] >= new_key);

    if (i == 0) begin : g_first
      assign key_below = key_r[i];
      assign tag_below = tag_r[i];
      assign ge_below  = 1'b0;
    end else begin : g_rest
      assign key_below = key_r[i-1];
      assign tag_below = tag_r[i-1];
      assign ge_below  = ge[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_top
      assign key_above = key_r[i];
      assign tag_above = tag_r[i];
    end else begin : g_mid
      assign key_above = key_r[i+1];
      assign tag_above = tag_r[i+1];
    end

    assign take_new = ge[i] || (cnt_t'(i) == fill_r);

    assign key_nxt[i] = cmd.insert ? (ge_below ? key_below :
                                      (take_new ? new_key : key_r[i])) :
                        (cmd.pop ? key_above : key_r[i]);
    assign tag_nxt[i] = cmd.insert ? (ge_below ? tag_below :
                                      (take_new ? in_tag : tag_r[i])) :
                        (cmd.pop ? tag_above : tag_r[i]);
  end

  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) begin
      fill_nxt = fill_r + cnt_t'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - cnt_t'(1);
    end
    if (cmd.drop) begin
      dropped_nxt = 1'b1;
    end else if (cmd.pop && stat.last) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign stat.full = (fill_r == cnt_t'(MAX_RECORDS));
  assign stat.last = (fill_r == cnt_t'(1));

  assign head_key = KEY_FIELD_W'(key_r[0]);
  assign head_tag = tag_r[0];
  assign dropped  = dropped_r;

endmodule

// ===== src/rsk_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsk_ctrl
// Load/emit controller: takes records until the set end mark, then hands
// out the held records one transfer at a time until the last one leaves.
// ---------------------------------------------------------------------------
module rsk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rsk_pkg::rsk_stat_t  stat,
  output rsk_pkg::rsk_cmd_t   cmd
);
  import rsk_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic in_xfer, out_xfer;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign cmd.insert = in_xfer && !stat.full;
  assign cmd.drop   = in_xfer && stat.full;
  assign cmd.pop    = out_xfer;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_final) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer && stat.last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/record_sorter_by_key.sv =====
// The first sorted result is valid in the cycle after the final record's transfer.
// Throughput: one record per cycle while loading; one result per cycle while emitting and out_if.ready is high.
// The insertion chain compares all cells at once, and emission shifts the chain
// one place per transfer.
// Reset (synchronous, active low) empties the store and clears the overflow flag;
// held record contents are not cleared.
// ---------------------------------------------------------------------------
// record_sorter_by_key
// Collects a set of key/tag records and emits them in ascending key order,
// equal keys newest first, flagging records dropped for lack of room.
// ---------------------------------------------------------------------------
module record_sorter_by_key (
  input  logic      clk,
  input  logic      rst_n,
  rsk_in_if.sink    in_if,
  rsk_out_if.source out_if
);
  import rsk_pkg::*;

  rsk_cmd_t  cmd;
  rsk_stat_t stat;

  rsk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_final  (in_if.final_record),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsk_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_key   (in_if.sort_key),
    .in_tag   (in_if.record_tag),
    .head_key (out_if.out_key),
    .head_tag (out_if.out_tag),
    .dropped  (out_if.overflow)
  );

  assign out_if.last_out = stat.last;

`ifndef ASSERT_OFF
  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input ready while results pending");

  // the set end mark starts emission in the next cycle
  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.final_record) |=> out_if.valid)
    else $error("emission did not start after final record");

  // after the last result transfer the block loads again
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last_out) |=> in_if.ready)
    else $error("block did not return to loading after last result");

  // a record is never dropped while the chain has room
  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> stat.full)
    else $error("record dropped with free cells");
`endif

endmodule
